@@ rtl/ccs_pkg.sv @@
package ccs_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned IDX_W       = 7;
    localparam int unsigned CFG_IDX_W   = 4;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned ROUNDS_W    = 5;

    // Byte index value that marks the keystream block as used up.
    localparam logic [IDX_W-1:0] BLOCK_BYTES = 7'd64;

    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 5'd20;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_01   = 4'd0,
        REG_KEY_23   = 4'd1,
        REG_KEY_45   = 4'd2,
        REG_KEY_67   = 4'd3,
        REG_NONCE_01 = 4'd4,
        REG_NONCE_2  = 4'd5,
        REG_START    = 4'd6,
        REG_ROUNDS   = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       cfg_we;
        logic       load;
        logic       step;
        logic [1:0] step_idx;
        logic       diag;
        logic       final_add;
        logic       take_byte;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic                need_block;
        logic [ROUNDS_W-1:0] dbl_rounds;
    } stat_t;

    // Builds the sixteen-word input state of one block.
    function automatic block_t init_state(
        input logic [3:0][CFG_DATA_W-1:0] key,
        input logic [CFG_DATA_W-1:0]      nonce01,
        input word_t                      nonce2,
        input word_t                      counter
    );
        block_t s;
        s[0]  = SIGMA_0;
        s[1]  = SIGMA_1;
        s[2]  = SIGMA_2;
        s[3]  = SIGMA_3;
        for (int k = 0; k < 4; k++)
        begin
            s[4 + 2 * k] = key[k][31:0];
            s[5 + 2 * k] = key[k][63:32];
        end
        s[12] = counter;
        s[13] = nonce01[31:0];
        s[14] = nonce01[63:32];
        s[15] = nonce2;
        return s;
    endfunction

endpackage

@@ rtl/ccs_ctrl.sv @@
module ccs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  ccs_pkg::stat_t  stat,
    output ccs_pkg::cmd_t   cmd
);

    ccs_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0]                     step_reg, step_next;
    logic                           diag_reg, diag_next;
    logic [ccs_pkg::ROUNDS_W-1:0]   dr_reg, dr_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ccs_pkg::ST_IDLE;
            step_reg      <= 2'd0;
            diag_reg      <= 1'b0;
            dr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            diag_reg      <= diag_next;
            dr_reg        <= dr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        diag_next     = diag_reg;
        dr_next       = dr_reg;
        cmd           = '0;
        cmd.step_idx  = step_reg;
        cmd.diag      = diag_reg;
        in_stall      = 1'b1;
        cfg_ready     = 1'b0;

        unique case (state_reg)
            ccs_pkg::ST_IDLE:
            begin
                cfg_ready     = 1'b1;
                cmd.cfg_we    = cfg_valid;
                in_stall      = !(slot_free && !stat.need_block);
                cmd.take_byte = in_valid && !in_stall;
                if (in_valid && stat.need_block)
                begin
                    state_next = ccs_pkg::ST_LOAD;
                end
            end
            ccs_pkg::ST_LOAD:
            begin
                cmd.load  = 1'b1;
                step_next = 2'd0;
                diag_next = 1'b0;
                dr_next   = '0;
                if (stat.dbl_rounds == '0)
                begin
                    state_next = ccs_pkg::ST_FINAL;
                end
                else
                begin
                    state_next = ccs_pkg::ST_ROUND;
                end
            end
            ccs_pkg::ST_ROUND:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    diag_next = !diag_reg;
                    if (diag_reg)
                    begin
                        dr_next = dr_reg + 1'b1;
                        if (dr_reg + 1'b1 == stat.dbl_rounds)
                        begin
                            state_next = ccs_pkg::ST_FINAL;
                        end
                    end
                end
            end
            ccs_pkg::ST_FINAL:
            begin
                cmd.final_add = 1'b1;
                state_next    = ccs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ccs_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = cmd.take_byte || (out_valid_reg && out_stall);
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/ccs_datapath.sv @@
module ccs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ccs_pkg::cmd_t                       cmd,
    output ccs_pkg::stat_t                      stat,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [7:0]                          in_byte,
    output logic [7:0]                          out_byte
);

    logic [3:0][ccs_pkg::CFG_DATA_W-1:0] key_reg, key_next;
    logic [ccs_pkg::CFG_DATA_W-1:0]      nonce01_reg, nonce01_next;
    ccs_pkg::word_t                      nonce2_reg, nonce2_next;
    ccs_pkg::word_t                      start_reg, start_next;
    logic [ccs_pkg::ROUNDS_W-1:0]        rounds_reg, rounds_next;
    ccs_pkg::word_t                      counter_reg, counter_next;
    logic [ccs_pkg::IDX_W-1:0]           idx_reg, idx_next;
    logic                                cfg_hit;

    ccs_pkg::block_t work_reg, work_next;
    ccs_pkg::block_t ks_reg;
    ccs_pkg::block_t init_w;
    ccs_pkg::block_t round_w;
    logic [7:0]      out_byte_reg;
    logic [ccs_pkg::ROUNDS_W:0] rounds_plus;
    ccs_pkg::word_t  ks_word;
    logic [7:0]      ks_byte;

    // Configuration registers and block position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            nonce01_reg <= '0;
            nonce2_reg  <= '0;
            start_reg   <= '0;
            rounds_reg  <= ccs_pkg::ROUNDS_RESET;
            counter_reg <= '0;
            idx_reg     <= ccs_pkg::BLOCK_BYTES;
        end
        else
        begin
            key_reg     <= key_next;
            nonce01_reg <= nonce01_next;
            nonce2_reg  <= nonce2_next;
            start_reg   <= start_next;
            rounds_reg  <= rounds_next;
            counter_reg <= counter_next;
            idx_reg     <= idx_next;
        end
    end

    always_comb
    begin
        key_next     = key_reg;
        nonce01_next = nonce01_reg;
        nonce2_next  = nonce2_reg;
        start_next   = start_reg;
        rounds_next  = rounds_reg;
        cfg_hit      = 1'b0;
        if (cmd.cfg_we)
        begin
            cfg_hit = 1'b1;
            unique case (ccs_pkg::cfg_reg_t'(cfg_index))
                ccs_pkg::REG_KEY_01:   key_next[0]  = cfg_data;
                ccs_pkg::REG_KEY_23:   key_next[1]  = cfg_data;
                ccs_pkg::REG_KEY_45:   key_next[2]  = cfg_data;
                ccs_pkg::REG_KEY_67:   key_next[3]  = cfg_data;
                ccs_pkg::REG_NONCE_01: nonce01_next = cfg_data;
                ccs_pkg::REG_NONCE_2:  nonce2_next  = cfg_data[31:0];
                ccs_pkg::REG_START:    start_next   = cfg_data[31:0];
                ccs_pkg::REG_ROUNDS:   rounds_next  = cfg_data[ccs_pkg::ROUNDS_W-1:0];
                default:               cfg_hit      = 1'b0;
            endcase
        end

        counter_next = counter_reg;
        idx_next     = idx_reg;
        if (cfg_hit)
        begin
            counter_next = start_next;
            idx_next     = ccs_pkg::BLOCK_BYTES;
        end
        else if (cmd.final_add)
        begin
            counter_next = counter_reg + 32'd1;
            idx_next     = '0;
        end
        else if (cmd.take_byte)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    assign init_w = ccs_pkg::init_state(key_reg, nonce01_reg, nonce2_reg, counter_reg);

    // Four quarter-round lanes, each doing one add-xor-rotate line per cycle.
    // In diagonal passes rows one to three are taken rotated left by their row number.
    always_comb
    begin
        logic [3:0][31:0] la, lb, lc, ld;
        logic [3:0][31:0] na, nb, nc, nd;
        logic [3:0][31:0] sum, mix, rot;

        for (int i = 0; i < 4; i++)
        begin
            la[i] = work_reg[i];
            lb[i] = cmd.diag ? work_reg[4 + ((i + 1) % 4)]  : work_reg[4 + i];
            lc[i] = cmd.diag ? work_reg[8 + ((i + 2) % 4)]  : work_reg[8 + i];
            ld[i] = cmd.diag ? work_reg[12 + ((i + 3) % 4)] : work_reg[12 + i];

            sum[i] = cmd.step_idx[0] ? (lc[i] + ld[i]) : (la[i] + lb[i]);
            mix[i] = (cmd.step_idx[0] ? lb[i] : ld[i]) ^ sum[i];
            case (cmd.step_idx)
                2'd0:    rot[i] = {mix[i][15:0], mix[i][31:16]};
                2'd1:    rot[i] = {mix[i][19:0], mix[i][31:20]};
                2'd2:    rot[i] = {mix[i][23:0], mix[i][31:24]};
                default: rot[i] = {mix[i][24:0], mix[i][31:25]};
            endcase

            na[i] = cmd.step_idx[0] ? la[i]  : sum[i];
            nb[i] = cmd.step_idx[0] ? rot[i] : lb[i];
            nc[i] = cmd.step_idx[0] ? sum[i] : lc[i];
            nd[i] = cmd.step_idx[0] ? ld[i]  : rot[i];
        end

        for (int j = 0; j < 4; j++)
        begin
            round_w[j]      = na[j];
            round_w[4 + j]  = cmd.diag ? nb[(j + 3) % 4] : nb[j];
            round_w[8 + j]  = cmd.diag ? nc[(j + 2) % 4] : nc[j];
            round_w[12 + j] = cmd.diag ? nd[(j + 1) % 4] : nd[j];
        end
    end

    always_comb
    begin
        work_next = work_reg;
        if (cmd.load)
        begin
            work_next = init_w;
        end
        else if (cmd.step)
        begin
            work_next = round_w;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (cmd.final_add)
        begin
            for (int k = 0; k < ccs_pkg::BLOCK_WORDS; k++)
            begin
                ks_reg[k] <= work_reg[k] + init_w[k];
            end
        end
        if (cmd.take_byte)
        begin
            out_byte_reg <= in_byte ^ ks_byte;
        end
    end

    assign ks_word = ks_reg[idx_reg[5:2]];
    assign ks_byte = ks_word[idx_reg[1:0] * 8 +: 8];

    assign rounds_plus     = {1'b0, rounds_reg} + 6'd1;
    assign stat.dbl_rounds = rounds_plus[ccs_pkg::ROUNDS_W:1];
    assign stat.need_block = idx_reg[ccs_pkg::IDX_W-1];
    assign out_byte        = out_byte_reg;

endmodule

@@ rtl/chacha_stream_cipher.sv @@
// A byte is accepted only when a keystream block is ready and appears on out_byte in the next cycle.
// Throughput: one byte per cycle inside a block while the output is not stalled; a new block
// is generated by the four-lane quarter-round step, and input bytes are stalled meanwhile.
// Reset (rst_n, asynchronous, active low) clears the key, nonce and counter, sets twenty rounds
// and marks the keystream block as used, so the first byte triggers block generation.
module chacha_stream_cipher (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          in_byte,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          out_byte,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // The controller sequences block generation and the byte handshake. The datapath
    // holds the configuration, the working state, the keystream block and the output
    // register. A transfer on the input side is only taken when a keystream byte is
    // available and the output register is free or is being emptied in the same cycle.

    ccs_pkg::cmd_t  cmd;
    ccs_pkg::stat_t stat;

    // Generation starts only when a byte is waiting and the current block is used up.
    // Configuration transfers are taken while no block is being generated; any write to
    // a known register reloads the block counter and forces a fresh block.
    ccs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath runs four quarter-round lanes together, one of their four
    // add-xor-rotate lines per cycle, alternating column and diagonal passes.
    ccs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (in_byte),
        .out_byte  (out_byte)
    );

endmodule
